// File: hdl/pfb_pkg.sv
// Shared types and constants for the packed 12-bit frame buffer.
`default_nettype none
package pfb_pkg;

    // Field widths
    localparam int COORD_W = 9;
    localparam int COLOR_W = 12;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int NIB_W   = PROD_W + 3;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_MONO  = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FG     = 2'd2;
    localparam logic [1:0] REG_BG     = 2'd3;

    // Memory address selection
    localparam logic [2:0] ADDR_LO    = 3'd0;
    localparam logic [2:0] ADDR_HI    = 3'd1;
    localparam logic [2:0] ADDR_MERGE = 3'd2;
    localparam logic [2:0] ADDR_FULL  = 3'd3;
    localparam logic [2:0] ADDR_FILL  = 3'd4;

    // Memory write data selection
    localparam logic [1:0] WR_FULL  = 2'd0;
    localparam logic [1:0] WR_MERGE = 2'd1;
    localparam logic [1:0] WR_FILL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_in;
        logic       do_mul;
        logic       do_addr;
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] addr_sel;
        logic [1:0] wr_sel;
        logic       keep_lo;
        logic       fill_clear;
        logic       fill_adv;
        logic       out_load;
    } pfb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       in_frame;
        logic       fill_more;
    } pfb_sts_t;

endpackage
`default_nettype wire

// File: hdl/pfb_in_if.sv
// Command channel interface: one pixel operation per transaction.
`default_nettype none
interface pfb_in_if;
    import pfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COLOR_W-1:0] color_in;
    logic               mono_bit;

    modport source (output valid, operation, pos_x, pos_y, color_in, mono_bit, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, color_in, mono_bit, output ready);
endinterface
`default_nettype wire

// File: hdl/pfb_out_if.sv
// Response channel interface: one result per transaction.
`default_nettype none
interface pfb_out_if;
    import pfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_out;
    logic               in_range;

    modport source (output valid, color_out, in_range, input ready);
    modport sink   (input valid, color_out, in_range, output ready);
endinterface
`default_nettype wire

// File: hdl/pfb_cfg_if.sv
// Configuration write channel interface.
`default_nettype none
interface pfb_cfg_if;
    import pfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         index;
    logic [COLOR_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/pfb_datapath.sv
// Datapath: config registers, address arithmetic, frame memory and result register.
`default_nettype none
module pfb_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pfb_pkg::pfb_cmd_t           cmd,
    output pfb_pkg::pfb_sts_t                sts,
    input  wire logic [1:0]                  in_operation,
    input  wire logic [pfb_pkg::COORD_W-1:0] in_pos_x,
    input  wire logic [pfb_pkg::COORD_W-1:0] in_pos_y,
    input  wire logic [pfb_pkg::COLOR_W-1:0] in_color,
    input  wire logic                        in_mono,
    input  wire logic                        cfg_valid,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [pfb_pkg::COLOR_W-1:0] cfg_data,
    output logic [pfb_pkg::COLOR_W-1:0]      color_out,
    output logic                             in_range
);
    import pfb_pkg::*;

    localparam int STORE_BYTES = (3 * MAX_WIDTH * MAX_HEIGHT + 1) / 2;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = AW + 1;

    logic [COORD_W-1:0] width_reg, height_reg;
    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic [COORD_W-1:0] eff_w, eff_h;

    logic [1:0]         op_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [COLOR_W-1:0] wcolor_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               inside_reg;
    logic [AW-1:0]      base_reg;
    logic               odd_reg;
    logic [CW-1:0]      n_reg, cnt_reg;
    logic [1:0]         k_reg;
    logic [7:0]         rdata_reg, byte0_reg;
    logic [COLOR_W-1:0] color_out_reg;
    logic               in_range_reg;

    logic [COORD_W-1:0] mul_a;
    logic [PROD_W:0]    idx;
    logic [NIB_W-1:0]   nib, fill_sum;
    logic [AW-1:0]      base_p1, mem_addr;
    logic [7:0]         wdata, pat;
    logic [COLOR_W-1:0] rd_color;

    logic [7:0] mem [STORE_BYTES];

    // Saturate the frame size to the store's dimensions
    always_comb
    begin
        eff_w = (32'(width_reg) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : width_reg;
        eff_h = (32'(height_reg) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : height_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COORD_W'(256);
            height_reg <= COORD_W'(256);
            fg_reg     <= COLOR_W'(4095);
            bg_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[COORD_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[COORD_W-1:0];
                REG_FG:     fg_reg     <= cfg_data;
                REG_BG:     bg_reg     <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Address arithmetic
    always_comb
    begin
        mul_a    = (op_reg == OP_FILL) ? eff_h : y_reg;
        idx      = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(x_reg);
        nib      = NIB_W'(idx) + (NIB_W'(idx) << 1);
        fill_sum = (NIB_W'(prod_reg) + (NIB_W'(prod_reg) << 1) + NIB_W'(1)) >> 1;
        base_p1  = base_reg + AW'(1);
    end

    // Capture the transaction, multiply, then form byte address and fill length
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_operation;
            x_reg      <= in_pos_x;
            y_reg      <= in_pos_y;
            wcolor_reg <= (in_operation == OP_MONO) ? (in_mono ? fg_reg : bg_reg) : in_color;
        end
        if (cmd.do_mul)
        begin
            prod_reg   <= mul_a * eff_w;
            inside_reg <= (x_reg < eff_w) && (y_reg < eff_h);
        end
        if (cmd.do_addr)
        begin
            base_reg <= AW'(nib >> 1);
            odd_reg  <= nib[0];
            n_reg    <= CW'(fill_sum);
        end
    end

    // Fill walk: byte counter and pattern phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            k_reg   <= '0;
        end
        else if (cmd.fill_clear)
        begin
            cnt_reg <= '0;
            k_reg   <= '0;
        end
        else if (cmd.fill_adv)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
        end
    end

    // Select memory address and write data
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_LO:    mem_addr = base_reg;
            ADDR_HI:    mem_addr = base_p1;
            ADDR_MERGE: mem_addr = odd_reg ? base_reg : base_p1;
            ADDR_FULL:  mem_addr = odd_reg ? base_p1 : base_reg;
            ADDR_FILL:  mem_addr = cnt_reg[AW-1:0];
            default:    mem_addr = base_reg;
        endcase

        case (k_reg)
            2'd0:    pat = wcolor_reg[11:4];
            2'd1:    pat = {wcolor_reg[3:0], wcolor_reg[11:8]};
            default: pat = wcolor_reg[7:0];
        endcase

        case (cmd.wr_sel)
            WR_FULL:  wdata = odd_reg ? wcolor_reg[7:0] : wcolor_reg[11:4];
            WR_MERGE: wdata = odd_reg ? {rdata_reg[7:4], wcolor_reg[11:8]}
                                      : {wcolor_reg[3:0], rdata_reg[3:0]};
            WR_FILL:  wdata = pat;
            default:  wdata = pat;
        endcase
    end

    // Frame memory, one byte port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[mem_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[mem_addr];
        end
        if (cmd.keep_lo)
        begin
            byte0_reg <= rdata_reg;
        end
    end

    // Unpack the read pixel from its two bytes
    always_comb
    begin
        rd_color = odd_reg ? {byte0_reg[3:0], rdata_reg} : {byte0_reg, rdata_reg[7:4]};
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            color_out_reg <= (op_reg == OP_READ && inside_reg) ? rd_color : '0;
            in_range_reg  <= (op_reg == OP_FILL) ? 1'b1 : inside_reg;
        end
    end

    assign color_out     = color_out_reg;
    assign in_range      = in_range_reg;
    assign sts.op        = op_reg;
    assign sts.in_frame  = inside_reg;
    assign sts.fill_more = cnt_reg < n_reg;

endmodule
`default_nettype wire

// File: hdl/pfb_ctrl.sv
// Controller: sequences each transaction through multiply, memory accesses and result.
`default_nettype none
module pfb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pfb_pkg::pfb_sts_t sts,
    output pfb_pkg::pfb_cmd_t      cmd
);
    import pfb_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_RD_A = 4'd3;
    localparam logic [3:0] S_RD_B = 4'd4;
    localparam logic [3:0] S_WR_A = 4'd5;
    localparam logic [3:0] S_WR_B = 4'd6;
    localparam logic [3:0] S_WR_C = 4'd7;
    localparam logic [3:0] S_FILL = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.addr_sel   = ADDR_LO;
        cmd.wr_sel     = WR_FULL;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.do_addr    = 1'b1;
                cmd.fill_clear = 1'b1;
                if (sts.op == OP_FILL)
                begin
                    state_next = S_FILL;
                end
                else if (!sts.in_frame)
                begin
                    state_next = S_DONE;
                end
                else if (sts.op == OP_READ)
                begin
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_WR_A;
                end
            end
            S_RD_A:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_LO;
                state_next   = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_HI;
                cmd.keep_lo  = 1'b1;
                state_next   = S_DONE;
            end
            S_WR_A:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_MERGE;
                state_next   = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_FULL;
                cmd.wr_sel   = WR_FULL;
                state_next   = S_WR_C;
            end
            S_WR_C:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_MERGE;
                cmd.wr_sel   = WR_MERGE;
                state_next   = S_DONE;
            end
            S_FILL:
            begin
                if (sts.fill_more)
                begin
                    cmd.mem_wr   = 1'b1;
                    cmd.addr_sel = ADDR_FILL;
                    cmd.wr_sel   = WR_FILL;
                    cmd.fill_adv = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The single memory port never reads and writes in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_rd && cmd.mem_wr))
        else $error("memory read and write in the same cycle");

    // An accepted transaction always starts the address multiply next
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MUL))
        else $error("accepted transaction did not start");

    // A new result appears only after the done state loaded it
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result valid without a finished transaction");

    // A merge write is always preceded by the write of the full byte
    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_C) |-> $past(state_reg == S_WR_B))
        else $error("merge write out of order");

endmodule
`default_nettype wire

// File: hdl/packed_12bpp_framebuffer_top.sv
// Top level of the packed 12-bit frame buffer.
`default_nettype none
// Pixels are RGB444, packed at three nibbles each in one byte-wide memory of
// (3*MAX_WIDTH*MAX_HEIGHT+1)/2 bytes. One transaction at a time is processed:
// a pixel or mono pixel write reads the byte it shares with a neighbour, then
// writes its own full byte and the merged shared byte; a pixel read reads its
// two bytes; any pixel operation outside the frame leaves the memory alone;
// and a fill writes n = ceil(3*width*height/2) bytes. All of these use the
// one memory port, which moves one byte per cycle. A finished result waits
// in an output register, so the next command is taken while it is still
// unclaimed; the result after it holds in the done state until that register
// is free. Configuration writes are always accepted and must happen only
// while idle.
module packed_12bpp_framebuffer_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfb_in_if.sink     cmd,
    pfb_out_if.source  rsp,
    pfb_cfg_if.sink    cfg
);
    import pfb_pkg::*;

    pfb_cmd_t dp_cmd;
    pfb_sts_t dp_sts;

    assign cfg.ready = 1'b1;

    // Sequencer
    pfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // Datapath and frame memory
    pfb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .in_operation (cmd.operation),
        .in_pos_x     (cmd.pos_x),
        .in_pos_y     (cmd.pos_y),
        .in_color     (cmd.color_in),
        .in_mono      (cmd.mono_bit),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .color_out    (rsp.color_out),
        .in_range     (rsp.in_range)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the packed 12-bit RGB444 frame buffer.
module testbench;
    import pfb_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int STORE_BYTES = (3 * MAX_W * MAX_H + 1) / 2;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 64;
    localparam int NUM_PHASES  = 14;
    localparam int PHASE_ITEMS = 45;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               mono;
    } pixel_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               in_range;
    } pixel_rsp_t;

    logic clk;
    logic rst_n;

    pfb_in_if  cmd ();
    pfb_out_if rsp ();
    pfb_cfg_if cfg ();

    packed_12bpp_framebuffer_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow of the frame store and of the registers
    logic [7:0]         pixel_store [STORE_BYTES];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;

    pixel_cmd_t pending_cmds [$];
    pixel_rsp_t expected_pixels [$];
    pixel_cmd_t cmd_on_bus;

    int mismatches;
    int cycles;
    bit gaps_on;
    int cmd_gap;
    int rsp_stall;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_width();
        return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none while gaps are off
    function automatic int pick_idle();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Update the shadow store for one command and compute its response
    task automatic apply_command(input pixel_cmd_t c, output pixel_rsp_t r);
        int                 w;
        int                 h;
        int                 nib;
        int                 b;
        int                 n;
        logic               in_frame;
        logic [COLOR_W-1:0] col;
        logic [7:0]         pat [3];
        w = eff_width();
        h = eff_height();
        in_frame = (c.x < w) && (c.y < h);
        r = '0;
        r.in_range = in_frame;
        nib = 3 * (int'(c.y) * w + int'(c.x));
        b = nib / 2;
        case (c.op)
            OP_WRITE, OP_MONO:
            begin
                if (in_frame)
                begin
                    if (c.op == OP_WRITE)
                        col = c.color;
                    else
                        col = c.mono ? fg_reg : bg_reg;
                    // Even offset: byte RG then high nibble of next; odd: low nibble then GB
                    if (nib % 2 == 0)
                    begin
                        pixel_store[b]     = col[11:4];
                        pixel_store[b + 1] = {col[3:0], pixel_store[b + 1][3:0]};
                    end
                    else
                    begin
                        pixel_store[b]     = {pixel_store[b][7:4], col[11:8]};
                        pixel_store[b + 1] = col[7:0];
                    end
                end
            end
            OP_READ:
            begin
                if (in_frame)
                begin
                    if (nib % 2 == 0)
                        r.color = {pixel_store[b], pixel_store[b + 1][7:4]};
                    else
                        r.color = {pixel_store[b][3:0], pixel_store[b + 1]};
                end
            end
            default:
            begin
                // Fill repeats RG, BR, GB over the whole frame
                col = c.color;
                pat[0] = col[11:4];
                pat[1] = {col[3:0], col[11:8]};
                pat[2] = col[7:0];
                n = (3 * w * h + 1) / 2;
                for (int i = 0; i < n && i < STORE_BYTES; i++)
                    pixel_store[i] = pat[i % 3];
                r.in_range = 1'b1;
            end
        endcase
    endtask

    task automatic queue_cmd(input logic [1:0] op, input int x, input int y,
                             input int color, input bit mono);
        pixel_cmd_t c;
        c.op    = op;
        c.x     = COORD_W'(x);
        c.y     = COORD_W'(y);
        c.color = COLOR_W'(color);
        c.mono  = mono;
        pending_cmds.push_back(c);
    endtask

    // Random command, mostly inside the frame, with a given fill percentage
    function automatic pixel_cmd_t random_cmd(int fill_pct);
        pixel_cmd_t c;
        int         pick;
        int         w;
        int         h;
        w = eff_width();
        h = eff_height();
        pick = $urandom_range(0, 99);
        if (pick < fill_pct)
            c.op = OP_FILL;
        else if (pick < fill_pct + 35)
            c.op = OP_WRITE;
        else if (pick < fill_pct + 70)
            c.op = OP_READ;
        else
            c.op = OP_MONO;
        if (w > 0 && h > 0 && $urandom_range(0, 99) < 85)
        begin
            c.x = COORD_W'($urandom_range(0, w - 1));
            c.y = COORD_W'($urandom_range(0, h - 1));
        end
        else
        begin
            c.x = COORD_W'($urandom);
            c.y = COORD_W'($urandom);
        end
        c.color = COLOR_W'($urandom);
        c.mono  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Hold until nothing is queued, on the bus or awaited
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd.valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [COLOR_W-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_WIDTH:  width_reg  = value[8:0];
            REG_HEIGHT: height_reg = value[8:0];
            REG_FG:     fg_reg     = value;
            default:    bg_reg     = value;
        endcase
    endtask

    // Command driver: predict on each transaction, then present the next item
    always @(posedge clk)
    begin : cmd_driver
        pixel_rsp_t predicted;
        if (cmd.valid && cmd.ready)
        begin
            apply_command(cmd_on_bus, predicted);
            expected_pixels.push_back(predicted);
        end
        if (!cmd.valid || cmd.ready)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd_on_bus = pending_cmds.pop_front();
                cmd.valid     <= 1'b1;
                cmd.operation <= cmd_on_bus.op;
                cmd.pos_x     <= cmd_on_bus.x;
                cmd.pos_y     <= cmd_on_bus.y;
                cmd.color_in  <= cmd_on_bus.color;
                cmd.mono_bit  <= cmd_on_bus.mono;
                cmd_gap = pick_idle();
            end
            else
            begin
                cmd.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare against the oldest expectation, then stall at random
    always @(posedge clk)
    begin : rsp_monitor
        pixel_rsp_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: color_out=%03h in_range=%0b",
                             rsp.color_out, rsp.in_range);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (rsp.color_out !== want.color || rsp.in_range !== want.in_range)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response error: color_out exp %03h got %03h, in_range exp %0b got %0b",
                                 want.color, rsp.color_out, want.in_range, rsp.in_range);
                end
            end
        end
        if (rsp_stall > 0)
        begin
            rsp_stall--;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rsp_stall = pick_idle();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("packed_12bpp_framebuffer_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [COLOR_W-1:0] wd;
        logic [COLOR_W-1:0] hd;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        int                 fill_pct;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.operation = OP_WRITE;
        cmd.pos_x     = '0;
        cmd.pos_y     = '0;
        cmd.color_in  = '0;
        cmd.mono_bit  = 1'b0;
        rsp.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = REG_WIDTH;
        cfg.data      = '0;
        width_reg     = 9'd256;
        height_reg    = 9'd256;
        fg_reg        = 12'hfff;
        bg_reg        = 12'h000;
        mismatches    = 0;
        cycles        = 0;
        cmd_gap       = 0;
        rsp_stall     = 0;
        gaps_on       = 1'b1;
        foreach (pixel_store[i])
            pixel_store[i] = 8'h00;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size fill first so that every byte is defined before any read
        queue_cmd(OP_FILL, 0, 0, 12'habc, 1'b0);
        queue_cmd(OP_READ, 0, 0, 0, 1'b0);
        queue_cmd(OP_READ, 1, 0, 0, 1'b0);
        // Even and odd offsets next to each other, then check the merge
        queue_cmd(OP_WRITE, 0, 0, 12'h123, 1'b0);
        queue_cmd(OP_WRITE, 1, 0, 12'h456, 1'b0);
        queue_cmd(OP_READ, 0, 0, 0, 1'b0);
        queue_cmd(OP_READ, 1, 0, 0, 1'b0);
        queue_cmd(OP_READ, 2, 0, 0, 1'b0);
        // Last pixel of the frame
        queue_cmd(OP_WRITE, 255, 255, 12'hfff, 1'b1);
        queue_cmd(OP_READ, 255, 255, 0, 1'b0);
        queue_cmd(OP_READ, 254, 255, 0, 1'b0);
        // Outside coordinates
        queue_cmd(OP_WRITE, 256, 0, 12'h000, 1'b0);
        queue_cmd(OP_WRITE, 0, 256, 12'hfff, 1'b1);
        queue_cmd(OP_READ, 511, 511, 0, 1'b0);
        queue_cmd(OP_READ, 256, 255, 0, 1'b0);
        queue_cmd(OP_MONO, 511, 0, 12'hfff, 1'b1);
        // Mono pixels with foreground and background
        queue_cmd(OP_MONO, 3, 7, 12'h000, 1'b1);
        queue_cmd(OP_MONO, 4, 7, 12'hfff, 1'b0);
        queue_cmd(OP_READ, 3, 7, 0, 1'b0);
        queue_cmd(OP_READ, 4, 7, 0, 1'b0);
        queue_cmd(OP_WRITE, 0, 1, 12'h000, 1'b0);
        queue_cmd(OP_READ, 0, 1, 0, 1'b0);
        wait_idle();

        // Random phases, each with its own frame setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            fg = COLOR_W'($urandom);
            bg = COLOR_W'($urandom);
            case (ph)
                0:
                begin
                    wd = 12'd256;
                    hd = 12'd256;
                    fg = 12'h000;
                    bg = 12'hfff;
                end
                1:
                begin
                    wd = 12'd1;
                    hd = 12'd1;
                    fg = 12'hfff;
                    bg = 12'h000;
                end
                2:
                begin
                    wd = 12'd0;
                    hd = 12'd5;
                end
                3:
                begin
                    wd = 12'd511;
                    hd = 12'd3;
                end
                4:
                begin
                    wd = 12'd4;
                    hd = 12'd300;
                end
                5:
                begin
                    // Bits above the register width are dropped
                    wd = 12'he07;
                    hd = 12'he05;
                end
                6:
                begin
                    wd = 12'd256;
                    hd = 12'd1;
                end
                7:
                begin
                    wd = 12'd1;
                    hd = 12'd256;
                end
                8:
                begin
                    wd = 12'd7;
                    hd = 12'd0;
                end
                default:
                begin
                    wd = COLOR_W'($urandom_range(1, 24));
                    hd = COLOR_W'($urandom_range(1, 24));
                end
            endcase
            write_reg(REG_WIDTH, wd);
            write_reg(REG_HEIGHT, hd);
            write_reg(REG_FG, fg);
            write_reg(REG_BG, bg);
            gaps_on = (ph % 4 != 3);
            // Keep fills to frames that are cheap to sweep
            fill_pct = (eff_width() * eff_height() > 4096) ? 0 : 4;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_cmds.push_back(random_cmd(fill_pct));
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("packed_12bpp_framebuffer_top: match");
        else
            $display("packed_12bpp_framebuffer_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hdl/pfb_pkg.sv
hdl/pfb_in_if.sv
hdl/pfb_out_if.sv
hdl/pfb_cfg_if.sv
hdl/pfb_datapath.sv
hdl/pfb_ctrl.sv
hdl/packed_12bpp_framebuffer_top.sv
sim/testbench.sv
